// ----- rtl/vcii_pkg.sv -----
package vcii_pkg;

  localparam int FREQ_W  = 24;
  localparam int VOLT_W  = 12;
  localparam int STEP_W  = 10;
  localparam int INDEX_W = 6;
  localparam int CODE_W  = 16;
  localparam int MV_W    = 12;
  localparam int COUNT_W = 7;

  localparam int MAX_POINTS_DEF = 64;
  localparam int STEPS_DEF      = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CODE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_MV   = 2'd2;

  localparam logic [COUNT_W-1:0] POINT_COUNT_RST     = 7'd61;
  localparam logic [CODE_W-1:0]  FULL_SCALE_CODE_RST = 16'd3780;
  localparam logic [MV_W-1:0]    FULL_SCALE_MV_RST   = 12'd3000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [VOLT_W-1:0] volts;
    logic [FREQ_W-1:0] freq;
  } curve_point_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RDL,
    S_T1,
    S_T2,
    S_SCAN,
    S_VRD,
    S_VRD2,
    S_NUM1,
    S_NUM2,
    S_NUM3,
    S_FIX,
    S_DEN,
    S_NLO,
    S_NHI,
    S_NACC,
    S_DIVGO,
    S_DIV
  } state_t;

endpackage

// ----- rtl/vcii_curve_mem.sv -----
module vcii_curve_mem #(
  parameter int DEPTH = vcii_pkg::MAX_POINTS_DEF,
  parameter int AIW   = $clog2(vcii_pkg::MAX_POINTS_DEF)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AIW-1:0]         waddr,
  input  vcii_pkg::curve_point_t wdata,
  input  logic [AIW-1:0]         raddr,
  output vcii_pkg::curve_point_t rdata
);
  import vcii_pkg::*;

  curve_point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/vcii_mul.sv -----
module vcii_mul #(
  parameter int AW = 43,
  parameter int BW = 17
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- rtl/vcii_divider.sv -----
module vcii_divider #(
  parameter int RW = 67
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [RW-1:0]                 dividend,
  input  logic [RW-1:0]                 divisor,
  output logic                          done,
  output logic [vcii_pkg::CODE_W-1:0]   quotient
);
  import vcii_pkg::*;

  localparam int CNW = $clog2(CODE_W + 1);

  logic              active;
  logic [CNW-1:0]    cnt;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     dsh;
  logic [CODE_W-1:0] q;
  logic              ge;
  logic [CODE_W-1:0] q_next;

  assign ge     = rem >= dsh;
  assign q_next = {q[CODE_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active) begin
        if (cnt == CNW'(CODE_W)) begin
          if (ge) begin
            done   <= 1'b1;
            active <= 1'b0;
          end
        end else if (cnt == '0) begin
          done   <= 1'b1;
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNW'(CODE_W);
      rem <= dividend;
      dsh <= divisor << CODE_W;
      q   <= '0;
    end else if (active) begin
      if (cnt == CNW'(CODE_W)) begin
        if (ge) begin
          quotient <= '1;
        end else begin
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
        end
      end else begin
        if (ge) begin
          rem <= rem - dsh;
        end
        if (cnt == '0) begin
          quotient <= q_next;
        end else begin
          q   <= q_next;
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/vco_curve_inverse_interpolator.sv -----
// A load transaction writes the curve memory when accepted and gives no result; busy stays low.
// A query transaction scans its segments one per cycle through the shared multiplier,
// then runs a 17-step serial division; a saturated code ends the division at its first
// step, and a non-positive voltage skips the division altogether.
// The result is shown for one cycle on done, when the next transaction can be accepted.
// Synchronous reset restores the register defaults; the curve memory is not cleared.
module vco_curve_inverse_interpolator #(
  parameter int MAX_POINTS = vcii_pkg::MAX_POINTS_DEF,
  parameter int STEPS      = vcii_pkg::STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic [vcii_pkg::INDEX_W-1:0]    point_index,
  input  logic [vcii_pkg::VOLT_W-1:0]     point_volts_mv,
  input  logic [vcii_pkg::FREQ_W-1:0]     point_freq,
  input  logic [vcii_pkg::STEP_W-1:0]     query_step,
  output logic                            done,
  output logic [vcii_pkg::CODE_W-1:0]     tuning_code,
  input  logic                            cfg_write,
  input  logic [vcii_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcii_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vcii_pkg::*;

  localparam int FW  = FREQ_W;
  localparam int VW  = VOLT_W;
  localparam int QW  = STEP_W;
  localparam int CW  = CODE_W;
  localparam int MW  = MV_W;
  localparam int AIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NCW = $clog2(MAX_POINTS + 1);
  localparam int SW  = $clog2(STEPS);
  localparam int PW  = (SW > QW) ? SW : QW;
  localparam int TW  = FW + PW + 2;
  localparam int DW  = FW + SW + 1;
  localparam int NW  = TW + VW + 3;
  localparam int HW  = (NW + 1) / 2;
  localparam int AW  = TW + 1;
  localparam int BW  = ((SW > CW) ? SW : CW) + 1;
  localparam int PRW = AW + BW;
  localparam int RW  = NW + CW;

  localparam logic [SW-1:0] S1 = SW'(STEPS - 1);

  state_t state, state_next;

  logic [COUNT_W-1:0] point_count;
  logic [CW-1:0]      full_scale_code;
  logic [MW-1:0]      full_scale_mv;

  logic accept;
  logic mem_we;
  logic [AIW-1:0] mem_raddr;
  curve_point_t   mem_wdata;
  curve_point_t   rd;

  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PRW-1:0] prod;

  logic              div_start;
  logic              div_done;
  logic [CW-1:0]     div_q;

  logic [QW-1:0]        q_r;
  logic [NCW-1:0]       n_r;
  logic [NCW-1:0]       n_clamp;
  logic [FW-1:0]        f0_r;
  logic [AIW-1:0]       j;
  logic signed [TW-1:0] t;
  logic signed [TW-1:0] fs_lo;
  logic signed [TW-1:0] fs_hi;
  logic signed [TW-1:0] fs_new;
  logic signed [DW-1:0] den_r;
  logic signed [AW-1:0] dt_r;
  logic [VW-1:0]        v1_r;
  logic signed [VW:0]   dv;
  logic signed [FW:0]   f_span;
  logic signed [NW-1:0] num;
  logic [RW-1:0]        nn;
  logic [RW-1:0]        dvs;
  logic                 hit;
  logic                 zero_res;

  function automatic logic [AIW-1:0] clamp_addr(input int a);
    if (a > MAX_POINTS - 1) begin
      clamp_addr = AIW'(MAX_POINTS - 1);
    end else begin
      clamp_addr = AIW'(a);
    end
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (opcode == OP_LOAD) && (int'(point_index) < MAX_POINTS);
  assign mem_wdata.volts = point_volts_mv;
  assign mem_wdata.freq  = point_freq;

  assign fs_new   = $signed(prod[TW-1:0]);
  assign hit      = (fs_new >= t) || (int'(j) == int'(n_r) - 2);
  assign dv       = $signed({1'b0, rd.volts}) - $signed({1'b0, v1_r});
  assign f_span   = $signed({1'b0, rd.freq}) - $signed({1'b0, f0_r});
  assign zero_res = num[NW-1] || (num == '0) || (full_scale_code == '0);

  always_comb begin
    if (point_count < COUNT_W'(2)) begin
      n_clamp = NCW'(2);
    end else if (int'(point_count) > MAX_POINTS) begin
      n_clamp = NCW'(MAX_POINTS);
    end else begin
      n_clamp = NCW'(point_count);
    end
  end

  vcii_curve_mem #(
    .DEPTH(MAX_POINTS),
    .AIW  (AIW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(AIW'(point_index)),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rd)
  );

  vcii_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  vcii_divider #(
    .RW(RW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(nn),
    .divisor (dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_raddr  = '0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && (opcode == OP_QUERY)) begin
          state_next = S_RDL;
        end
      end
      S_RDL: begin
        mem_raddr  = AIW'(int'(n_r) - 1);
        mul_a      = $signed(AW'(rd.freq));
        mul_b      = $signed(BW'(S1));
        state_next = S_T1;
      end
      S_T1: begin
        mem_raddr  = clamp_addr(1);
        mul_a      = AW'(f_span);
        mul_b      = $signed(BW'(q_r));
        state_next = S_T2;
      end
      S_T2: begin
        mem_raddr  = clamp_addr(2);
        mul_a      = $signed(AW'(rd.freq));
        mul_b      = $signed(BW'(S1));
        state_next = S_SCAN;
      end
      S_SCAN: begin
        mem_raddr = clamp_addr(int'(j) + 3);
        mul_a     = $signed(AW'(rd.freq));
        mul_b     = $signed(BW'(S1));
        if (hit) begin
          state_next = S_VRD;
        end
      end
      S_VRD: begin
        mem_raddr  = j;
        state_next = S_VRD2;
      end
      S_VRD2: begin
        mem_raddr  = clamp_addr(int'(j) + 1);
        state_next = S_NUM1;
      end
      S_NUM1: begin
        mul_a      = dt_r;
        mul_b      = BW'(dv);
        state_next = S_NUM2;
      end
      S_NUM2: begin
        mul_a      = AW'(den_r);
        mul_b      = $signed(BW'(v1_r));
        state_next = S_NUM3;
      end
      S_NUM3: begin
        state_next = S_FIX;
      end
      S_FIX: begin
        state_next = S_DEN;
      end
      S_DEN: begin
        mul_a = AW'(den_r);
        mul_b = $signed(BW'(full_scale_mv));
        if (zero_res) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_NLO;
        end
      end
      S_NLO: begin
        mul_a      = $signed(AW'(num[HW-1:0]));
        mul_b      = $signed(BW'(full_scale_code));
        state_next = S_NHI;
      end
      S_NHI: begin
        mul_a      = $signed(AW'(num[NW-1:HW]));
        mul_b      = $signed(BW'(full_scale_code));
        state_next = S_NACC;
      end
      S_NACC: begin
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done            <= 1'b0;
      point_count     <= POINT_COUNT_RST;
      full_scale_code <= FULL_SCALE_CODE_RST;
      full_scale_mv   <= FULL_SCALE_MV_RST;
    end else begin
      done <= ((state == S_DEN) && zero_res) || ((state == S_DIV) && div_done);
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_POINT_COUNT:     point_count     <= cfg_data[COUNT_W-1:0];
          CFG_FULL_SCALE_CODE: full_scale_code <= cfg_data[CW-1:0];
          CFG_FULL_SCALE_MV:   full_scale_mv   <= cfg_data[MW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q_r <= query_step;
        n_r <= n_clamp;
      end
      S_RDL: begin
        f0_r <= rd.freq;
      end
      S_T1: begin
        t     <= fs_new;
        fs_lo <= fs_new;
      end
      S_T2: begin
        t <= t + $signed(prod[TW-1:0]);
        j <= '0;
      end
      S_SCAN: begin
        if (hit) begin
          fs_hi <= fs_new;
        end else begin
          fs_lo <= fs_new;
          j     <= j + 1'b1;
        end
      end
      S_VRD: begin
        den_r <= DW'(fs_hi - fs_lo);
        dt_r  <= AW'(t) - AW'(fs_lo);
      end
      S_VRD2: begin
        v1_r <= rd.volts;
      end
      S_NUM2: begin
        num <= $signed(prod[NW-1:0]);
      end
      S_NUM3: begin
        num <= num + $signed(prod[NW-1:0]);
      end
      S_FIX: begin
        if (den_r == '0) begin
          num   <= NW'(v1_r);
          den_r <= DW'(1);
        end else if (den_r[DW-1]) begin
          num   <= -num;
          den_r <= -den_r;
        end
      end
      S_DEN: begin
        if (zero_res) begin
          tuning_code <= '0;
        end
      end
      S_NLO: begin
        dvs <= RW'(prod[PRW-2:0]);
      end
      S_NHI: begin
        nn <= RW'(prod[PRW-2:0]);
      end
      S_NACC: begin
        nn <= nn + (RW'(prod[PRW-2:0]) << HW);
      end
      S_DIV: begin
        if (div_done) begin
          tuning_code <= div_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
